@@ rtl/core/scpd_pkg.sv @@
// Shared types, constants and the CRC-16 byte step for the sync/CRC-16 deframer.
// No dependencies; imported by scpd_parser and the top level.
`default_nettype none

package scpd_pkg;

  localparam logic [7:0]  SYNC_A   = 8'h3E;  // '>'
  localparam logic [7:0]  SYNC_B   = 8'h2A;  // '*'
  localparam logic [15:0] CRC_INIT = 16'h00FF;

  localparam int unsigned NumTypeWords = 4;

  typedef struct packed {
    logic [NumTypeWords-1:0][63:0] types;
    logic [7:0]                    ack_mask;
  } cfg_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        packet_done;
    logic        crc_ok;
    logic        type_known;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [7:0]  frame_length;
    logic        ack_request;
    logic [31:0] frames_seen;
    logic [31:0] frames_good;
  } res_t;

  // Reflected CCITT (poly 0x8408) update, one byte per call.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] d;
    d = b ^ crc[7:0];
    d = d ^ {d[3:0], 4'h0};
    return {d, crc[15:8]} ^ {12'h000, d[7:4]} ^ {5'h00, d, 3'b000};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/scpd_parser.sv @@
// Frame parser: phase sequencer, running CRC, held header fields and counters.
// Depends on scpd_pkg; state advances only when step_i is high.
`default_nettype none

module scpd_parser
  import scpd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire cfg_t       cfg_i,
  output res_t            res_o
);

  localparam logic [3:0] PH_HUNT   = 4'd0;
  localparam logic [3:0] PH_SYNC_B = 4'd1;
  localparam logic [3:0] PH_SYNC_C = 4'd2;
  localparam logic [3:0] PH_LENGTH = 4'd3;
  localparam logic [3:0] PH_TYPE   = 4'd4;
  localparam logic [3:0] PH_FLAGS  = 4'd5;
  localparam logic [3:0] PH_DATA   = 4'd6;
  localparam logic [3:0] PH_CRC_LO = 4'd7;
  localparam logic [3:0] PH_CRC_HI = 4'd8;

  logic [3:0]  phase_q, phase_d;
  logic [7:0]  length_q, length_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [31:0] seen_q, seen_d;
  logic [31:0] good_q, good_d;

  logic        pv, done, ok, known;
  logic [7:0]  pidx;
  logic [63:0] type_word;

  assign type_word = cfg_i.types[type_q[7:6]];

  always_comb begin
    phase_d  = phase_q;
    length_d = length_q;
    left_d   = left_q;
    type_d   = type_q;
    flags_d  = flags_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    seen_d   = seen_q;
    good_d   = good_q;
    pv       = 1'b0;
    pidx     = 8'h00;
    done     = 1'b0;
    ok       = 1'b0;
    known    = 1'b0;
    unique case (phase_q)
      PH_HUNT: begin
        phase_d  = (byte_i == SYNC_A) ? PH_SYNC_B : PH_HUNT;
        length_d = 8'h00;
        left_d   = 8'h00;
        flags_d  = 8'h00;
        crc_lo_d = 8'h00;
        crc_d    = CRC_INIT;
      end
      PH_SYNC_B: phase_d = (byte_i == SYNC_B) ? PH_SYNC_C : PH_HUNT;
      PH_SYNC_C: phase_d = (byte_i == SYNC_A) ? PH_LENGTH : PH_HUNT;
      PH_LENGTH: begin
        length_d = byte_i;
        phase_d  = PH_TYPE;
      end
      PH_TYPE: begin
        type_d = byte_i;
        if (length_q == 8'h00) begin
          // empty frame: drop it and hunt again
          phase_d = PH_HUNT;
        end else begin
          left_d  = length_q;
          crc_d   = crc_step(CRC_INIT, byte_i);
          phase_d = PH_FLAGS;
        end
      end
      PH_FLAGS: begin
        flags_d = byte_i;
        crc_d   = crc_step(crc_q, byte_i);
        phase_d = PH_DATA;
      end
      PH_DATA: begin
        pv     = 1'b1;
        pidx   = length_q - left_q;
        crc_d  = crc_step(crc_q, byte_i);
        left_d = left_q - 8'd1;
        if (left_d == 8'h00) begin
          phase_d = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        crc_lo_d = byte_i;
        phase_d  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        done    = 1'b1;
        seen_d  = seen_q + 32'd1;
        ok      = ({byte_i, crc_lo_q} == crc_q);
        if (ok) begin
          good_d = good_q + 32'd1;
        end
        known   = type_word[type_q[5:0]];
        phase_d = PH_HUNT;
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  always_comb begin
    res_o.payload_valid = pv;
    res_o.payload_byte  = pv ? byte_i : 8'h00;
    res_o.payload_index = pidx;
    res_o.packet_done   = done;
    res_o.crc_ok        = ok;
    res_o.type_known    = known;
    res_o.frame_type    = type_d;
    res_o.frame_flags   = flags_d;
    res_o.frame_length  = length_d;
    res_o.ack_request   = ok && known && ((flags_q & cfg_i.ack_mask) != 8'h00);
    res_o.frames_seen   = seen_d;
    res_o.frames_good   = good_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      length_q <= 8'h00;
      left_q   <= 8'h00;
      type_q   <= 8'h00;
      flags_q  <= 8'h00;
      crc_q    <= CRC_INIT;
      crc_lo_q <= 8'h00;
      seen_q   <= 32'h0;
      good_q   <= 32'h0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      length_q <= length_d;
      left_q   <= left_d;
      type_q   <= type_d;
      flags_q  <= flags_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
      seen_q   <= seen_d;
      good_q   <= good_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sync_crc16_packet_deframer_top.sv @@
// Sync/length/CRC-16 packet deframer, top level. Depends on scpd_pkg, scpd_parser.
// A byte in the input register passes the combinational CRC byte step and phase
//   update, and its result word is loaded into the result register for the outputs.
// Throughput: one byte per cycle unless the result side stalls.
// Reset (rst_ni low, async): hunt for sync, CRC 0x00FF, counters 0, type bitmap 0,
//   ack mask 1, both pipeline stages empty.
`default_nettype none

module sync_crc16_packet_deframer_top
  import scpd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // received byte channel
  input  wire logic        rx_valid_i,
  output logic             rx_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  // result channel
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output logic             payload_valid_o,
  output logic [7:0]       payload_byte_o,
  output logic [7:0]       payload_index_o,
  output logic             packet_done_o,
  output logic             crc_ok_o,
  output logic             type_known_o,
  output logic [7:0]       frame_type_o,
  output logic [7:0]       frame_flags_o,
  output logic [7:0]       frame_length_o,
  output logic             ack_request_o,
  output logic [31:0]      frames_seen_o,
  output logic [31:0]      frames_good_o,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  // register map, 8-byte stride
  localparam logic [2:0] REG_TYPES0   = 3'd0;
  localparam logic [2:0] REG_TYPES1   = 3'd1;
  localparam logic [2:0] REG_TYPES2   = 3'd2;
  localparam logic [2:0] REG_TYPES3   = 3'd3;
  localparam logic [2:0] REG_ACK_MASK = 3'd4;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cfg_t       cfg_q;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.types    <= '0;
      cfg_q.ack_mask <= 8'h01;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TYPES0:   cfg_q.types[0]  <= pwdata;
        REG_TYPES1:   cfg_q.types[1]  <= pwdata;
        REG_TYPES2:   cfg_q.types[2]  <= pwdata;
        REG_TYPES3:   cfg_q.types[3]  <= pwdata;
        REG_ACK_MASK: cfg_q.ack_mask  <= pwdata[7:0];
        default: ;  // unmapped: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TYPES0:   prdata = cfg_q.types[0];
      REG_TYPES1:   prdata = cfg_q.types[1];
      REG_TYPES2:   prdata = cfg_q.types[2];
      REG_TYPES3:   prdata = cfg_q.types[3];
      REG_ACK_MASK: prdata = {56'h0, cfg_q.ack_mask};
      default:      prdata = 64'h0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Two-stage pipeline: input register -> parser -> result register.
  // The input stage moves on whenever the result register is empty or being
  // drained, so a byte is taken every cycle unless the result side stalls.
  // ---------------------------------------------------------------------------
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  res_t       out_q;
  res_t       step_res;
  logic       advance;

  assign advance    = in_valid_q && (!out_valid_q || res_ready_i);
  assign rx_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_ready_o) begin
      in_valid_q <= rx_valid_i;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (rx_ready_o && rx_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // parser state advances exactly once per byte, as it enters the result register
  scpd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .cfg_i  (cfg_q),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold the result word until it is taken
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign res_valid_o     = out_valid_q;
  assign payload_valid_o = out_q.payload_valid;
  assign payload_byte_o  = out_q.payload_byte;
  assign payload_index_o = out_q.payload_index;
  assign packet_done_o   = out_q.packet_done;
  assign crc_ok_o        = out_q.crc_ok;
  assign type_known_o    = out_q.type_known;
  assign frame_type_o    = out_q.frame_type;
  assign frame_flags_o   = out_q.frame_flags;
  assign frame_length_o  = out_q.frame_length;
  assign ack_request_o   = out_q.ack_request;
  assign frames_seen_o   = out_q.frames_seen;
  assign frames_good_o   = out_q.frames_good;

endmodule

`default_nettype wire

@@ rtl/core/scpd_checker.sv @@
// Port-level checks for the deframer top level, and the bind that attaches them.
// Depends only on the top level's ports.
`default_nettype none

module scpd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       res_valid_o,
  input wire logic       res_ready_i,
  input wire logic       payload_valid_o,
  input wire logic [7:0] payload_index_o,
  input wire logic [7:0] frame_length_o,
  input wire logic       packet_done_o,
  input wire logic       crc_ok_o,
  input wire logic       type_known_o,
  input wire logic       ack_request_o
);

  // a stalled result word stays offered
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o)
    else $error("result valid dropped while stalled");

  // a byte is either payload or the closing CRC byte, never both
  a_done_not_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(payload_valid_o && packet_done_o))
    else $error("payload and frame end in one word");

  // ack needs a finished, good, known frame
  a_ack_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && ack_request_o |-> packet_done_o && crc_ok_o && type_known_o)
    else $error("ack request without a good known frame");

  // payload index stays inside the announced length
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && payload_valid_o |-> payload_index_o < frame_length_o)
    else $error("payload index beyond frame length");

endmodule

bind sync_crc16_packet_deframer_top scpd_checker u_scpd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_o     (res_valid_o),
  .res_ready_i     (res_ready_i),
  .payload_valid_o (payload_valid_o),
  .payload_index_o (payload_index_o),
  .frame_length_o  (frame_length_o),
  .packet_done_o   (packet_done_o),
  .crc_ok_o        (crc_ok_o),
  .type_known_o    (type_known_o),
  .ack_request_o   (ack_request_o)
);

`default_nettype wire
